/* design/dipsc_pkg.sv */
// Shared types, constants and register indexes for the dual PI speed control block.
// No dependencies; imported by every module of the block.
package dipsc_pkg;

  // Encoder counter width and field widths
  localparam int COUNTER_BITS = 16;
  localparam int DATA_W       = 16;
  localparam int WRAP_W       = 4;
  localparam int IDX_W        = 3;

  // Arithmetic widths, derived from the counter width
  localparam int DELTA_W = COUNTER_BITS + 6;
  localparam int CALC_W  = ((COUNTER_BITS > DATA_W) ? COUNTER_BITS : DATA_W) + 7;
  localparam int ERR_W   = (CALC_W > 32) ? 32 : CALC_W;
  localparam int PROD_W  = ERR_W + 18;
  localparam int ACC_W   = PROD_W + 1;
  localparam int QUO_W   = ACC_W - 8;
  localparam int SUM_W   = QUO_W + 1;

  // Reset values of the configuration registers
  localparam logic [DATA_W-1:0] PROP_GAIN_RST  = 16'd14080;
  localparam logic [DATA_W-1:0] INTEG_GAIN_RST = 16'd768;
  localparam logic [DATA_W-1:0] TARGET_RST     = 16'd0;
  localparam logic [DATA_W-1:0] DUTY_LIMIT_RST = 16'd16800;

  // Configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_PROP_GAIN    = 3'd0,
    REG_INTEG_GAIN   = 3'd1,
    REG_TARGET_RIGHT = 3'd2,
    REG_TARGET_LEFT  = 3'd3,
    REG_DUTY_LIMIT   = 3'd4
  } reg_idx_e;

  // Register file contents
  typedef struct packed {
    logic [DATA_W-1:0] prop_gain;
    logic [DATA_W-1:0] integ_gain;
    logic [DATA_W-1:0] target_right;
    logic [DATA_W-1:0] target_left;
    logic [DATA_W-1:0] duty_limit;
  } cfg_t;

  // Settings one motor lane needs
  typedef struct packed {
    logic [DATA_W-1:0] prop_gain;
    logic [DATA_W-1:0] integ_gain;
    logic [DATA_W-1:0] target;
    logic [DATA_W-1:0] duty_limit;
  } lane_cfg_t;

  // Input request: one sampling tick
  typedef struct packed {
    logic [DATA_W-1:0] capture_right;
    logic              backward_right;
    logic [WRAP_W-1:0] wraps_right;
    logic [DATA_W-1:0] capture_left;
    logic              backward_left;
    logic [WRAP_W-1:0] wraps_left;
    logic              run_enable;
  } in_req_t;

  // Output request: duty values after the tick
  typedef struct packed {
    logic [DATA_W-1:0] duty_right;
    logic [DATA_W-1:0] duty_left;
  } out_req_t;

endpackage

/* design/dipsc_cfg.sv */
// Configuration register file for the dual PI speed control block.
// Depends on dipsc_pkg.
module dipsc_cfg import dipsc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_idx_i,
  input  logic [DATA_W-1:0] cfg_wdata_i,
  output cfg_t             cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Decode the write; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_PROP_GAIN:    cfg_d.prop_gain    = cfg_wdata_i;
        REG_INTEG_GAIN:   cfg_d.integ_gain   = cfg_wdata_i;
        REG_TARGET_RIGHT: cfg_d.target_right = cfg_wdata_i;
        REG_TARGET_LEFT:  cfg_d.target_left  = cfg_wdata_i;
        REG_DUTY_LIMIT:   cfg_d.duty_limit   = cfg_wdata_i;
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain    <= PROP_GAIN_RST;
      cfg_q.integ_gain   <= INTEG_GAIN_RST;
      cfg_q.target_right <= TARGET_RST;
      cfg_q.target_left  <= TARGET_RST;
      cfg_q.duty_limit   <= DUTY_LIMIT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* design/dipsc_lane.sv */
// One motor lane: count delta, incremental PI update and duty clamp, with its state.
// Depends on dipsc_pkg.
module dipsc_lane import dipsc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic [DATA_W-1:0] capture_i,
  input  logic              backward_i,
  input  logic [WRAP_W-1:0] wraps_i,
  input  logic              run_i,
  input  lane_cfg_t         cfg_i,
  output logic [DATA_W-1:0] duty_o
);

  logic [COUNTER_BITS-1:0] prev_capture_q;
  logic signed [ERR_W-1:0] prev_error_q, prev_error_d;
  logic [DATA_W-1:0]       duty_q, duty_d;

  logic [COUNTER_BITS-1:0]      cur;
  logic signed [DELTA_W-1:0]    cur_s, last_s, wrap_s, delta;
  logic signed [CALC_W-1:0]     err_raw;
  logic [CALC_W-ERR_W:0]        err_top;
  logic signed [ERR_W-1:0]      err;
  logic signed [ERR_W:0]        err_diff;
  logic signed [PROD_W-1:0]     prod_p, prod_i;
  logic signed [ACC_W-1:0]      acc, acc_adj;
  logic signed [QUO_W-1:0]      quo;
  logic signed [SUM_W-1:0]      sum;

  // Count delta since the last tick, wraps weighted by the largest counter value
  always_comb begin
    cur    = COUNTER_BITS'(capture_i);
    cur_s  = $signed(DELTA_W'(cur));
    last_s = $signed(DELTA_W'(prev_capture_q));
    wrap_s = $signed(DELTA_W'({wraps_i, {COUNTER_BITS{1'b0}}}) - DELTA_W'(wraps_i));
    delta  = (backward_i ? (last_s - cur_s) : (cur_s - last_s)) + wrap_s;
  end

  // Speed error, saturated to the error register range
  always_comb begin
    err_raw = $signed({{(CALC_W-DATA_W){1'b0}}, cfg_i.target})
            - $signed({{(CALC_W-DELTA_W){delta[DELTA_W-1]}}, delta});
    err_top = err_raw[CALC_W-1:ERR_W-1];
    if (err_top == '0 || err_top == '1) begin
      err = err_raw[ERR_W-1:0];
    end else if (err_raw[CALC_W-1]) begin
      err = {1'b1, {(ERR_W-1){1'b0}}};
    end else begin
      err = {1'b0, {(ERR_W-1){1'b1}}};
    end
  end

  // Incremental PI: Q8.8 gains, quotient truncated toward zero
  always_comb begin
    err_diff = $signed({err[ERR_W-1], err}) - $signed({prev_error_q[ERR_W-1], prev_error_q});
    prod_p   = $signed({1'b0, cfg_i.prop_gain}) * err_diff;
    prod_i   = $signed({1'b0, cfg_i.integ_gain}) * err;
    acc      = $signed({prod_p[PROD_W-1], prod_p}) + $signed({prod_i[PROD_W-1], prod_i});
    acc_adj  = acc + (acc[ACC_W-1] ? $signed(ACC_W'(255)) : $signed(ACC_W'(0)));
    quo      = acc_adj[ACC_W-1:8];
    sum      = $signed(SUM_W'(duty_q)) + $signed({quo[QUO_W-1], quo});
  end

  // Clamp and state update selection
  always_comb begin
    duty_d       = duty_q;
    prev_error_d = prev_error_q;
    if (run_i) begin
      prev_error_d = err;
      if (sum[SUM_W-1]) begin
        duty_d = '0;
      end else if (sum > $signed(SUM_W'(cfg_i.duty_limit))) begin
        duty_d = cfg_i.duty_limit;
      end else begin
        duty_d = sum[DATA_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_capture_q <= '0;
      prev_error_q   <= '0;
      duty_q         <= '0;
    end else if (fire_i) begin
      prev_capture_q <= cur;
      prev_error_q   <= prev_error_d;
      duty_q         <= duty_d;
    end
  end

  assign duty_o = duty_d;

endmodule

/* design/dual_incremental_pi_speed_control.sv */
// Top level of the dual incremental PI speed control block: handshake stages,
// register file and two motor lanes. Depends on dipsc_pkg, dipsc_cfg, dipsc_lane.
//
// Usage:
//   Input channel in_valid_i / in_stall_o / in_req_i carries one sampling tick
//   (two encoder captures, directions, wrap counts, run flag). Output channel
//   out_valid_o / out_stall_i / out_req_o returns the two duty values after
//   that tick, exactly one response per request, in order.
//   Latency: a request taken lands in the input register, passes through
//   the lane logic when the result register can load and shows on out_req_o
//   from the result register. Throughput: one request per cycle while the
//   result register is not held by out_stall_i, set by the single pass.
//   Stall: while the result register holds an unread response and
//   out_stall_i is high, the input register cannot drain; in_stall_o rises
//   only when the input register is also full. Nothing is dropped.
//   Reset: clears both stages, the lane state (last captures, last errors,
//   held duties) and loads the default gains, targets and duty limit.
//   Configuration writes (cfg_we_i, cfg_idx_i, cfg_wdata_i) take effect at
//   the next edge; write them only while no request is in flight.
module dual_incremental_pi_speed_control import dipsc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [IDX_W-1:0]  cfg_idx_i,
  input  logic [DATA_W-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_req_t           in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_req_t          out_req_o
);

  cfg_t      cfg;
  lane_cfg_t cfg_right, cfg_left;

  logic     in_valid_q, in_valid_d;
  in_req_t  in_q;
  logic     out_valid_q, out_valid_d;
  out_req_t out_q, out_d;
  logic     out_ready, fire, in_take;

  // Handshake: the input stage drains whenever the result register can load
  assign out_ready   = !out_valid_q || !out_stall_i;
  assign fire        = in_valid_q && out_ready;
  assign in_stall_o  = in_valid_q && !out_ready;
  assign in_take     = in_valid_i && !in_stall_o;
  assign in_valid_d  = in_take || (in_valid_q && !fire);
  assign out_valid_d = fire || (out_valid_q && out_stall_i);

  dipsc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Per-lane settings
  always_comb begin
    cfg_right.prop_gain  = cfg.prop_gain;
    cfg_right.integ_gain = cfg.integ_gain;
    cfg_right.target     = cfg.target_right;
    cfg_right.duty_limit = cfg.duty_limit;
    cfg_left             = cfg_right;
    cfg_left.target      = cfg.target_left;
  end

  dipsc_lane u_lane_right (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .capture_i  (in_q.capture_right),
    .backward_i (in_q.backward_right),
    .wraps_i    (in_q.wraps_right),
    .run_i      (in_q.run_enable),
    .cfg_i      (cfg_right),
    .duty_o     (out_d.duty_right)
  );

  dipsc_lane u_lane_left (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .capture_i  (in_q.capture_left),
    .backward_i (in_q.backward_left),
    .wraps_i    (in_q.wraps_left),
    .run_i      (in_q.run_enable),
    .cfg_i      (cfg_left),
    .duty_o     (out_d.duty_left)
  );

  // Valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_req_i;
    end
    if (fire) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  // A processed request always leaves a response behind
  a_fire_gives_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_o)
    else $error("processed request produced no response");

  // Input back-pressure only comes from a blocked result register
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i && in_valid_q))
    else $error("input stalled without a blocked output");

  // A PI update leaves both duties within the limit
  a_duty_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && in_q.run_enable) |=>
      (out_req_o.duty_right <= $past(cfg.duty_limit)) &&
      (out_req_o.duty_left <= $past(cfg.duty_limit)))
    else $error("duty above limit after PI update");

endmodule

/* verif/dipsc_checker.sv */
// Scoreboard for the dual incremental PI speed control block: tracks register writes,
// predicts the duty pair for every accepted tick request and compares the responses.
// Depends on dipsc_pkg.
module dipsc_checker import dipsc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [IDX_W-1:0]  cfg_idx_i,
  input  logic [DATA_W-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  in_req_t           in_req_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  out_req_t          out_req_i,
  output int                fail_cnt_o,
  output int                pending_o
);

  localparam longint CNT_MASK    = (longint'(1) << COUNTER_BITS) - 1;
  localparam longint WRAP_WEIGHT = CNT_MASK;
  localparam longint ERR_MAX     = 64'sd2147483647;
  localparam longint ERR_MIN     = -64'sd2147483648;

  // Shadow registers and per-motor state (0 = right, 1 = left)
  cfg_t              cfg;
  logic [DATA_W-1:0] last_cap  [2];
  int                last_err  [2];
  logic [DATA_W-1:0] duty_held [2];

  // Duty pairs still owed by the block, oldest first
  out_req_t duty_q [$];

  // One motor: count delta, then the incremental PI step when enabled
  function automatic void run_lane(input int m, input logic [DATA_W-1:0] cap,
                                   input logic back, input logic [WRAP_W-1:0] wraps,
                                   input logic run, input logic [DATA_W-1:0] target);
    longint cur, prv, wr, delta, err, acc, duty, kp, ki, lim, tgt;
    cur = cap;
    cur = cur & CNT_MASK;
    prv = last_cap[m];
    wr  = wraps;
    delta = back ? (prv - cur) : (cur - prv);
    delta = delta + WRAP_WEIGHT * wr;
    last_cap[m] = cur[DATA_W-1:0];
    if (run) begin
      tgt = target;
      kp  = cfg.prop_gain;
      ki  = cfg.integ_gain;
      lim = cfg.duty_limit;
      err = tgt - delta;
      if (err > ERR_MAX) err = ERR_MAX;
      if (err < ERR_MIN) err = ERR_MIN;
      acc = kp * (err - longint'(last_err[m])) + ki * err;
      last_err[m] = int'(err);
      // integer division truncates toward zero
      duty = longint'(duty_held[m]) + acc / 256;
      if (duty > lim) duty = lim;
      else if (duty < 0) duty = 0;
      duty_held[m] = duty[DATA_W-1:0];
    end
  endfunction

  function automatic out_req_t predict_duties(input in_req_t t);
    out_req_t r;
    run_lane(0, t.capture_right, t.backward_right, t.wraps_right, t.run_enable,
             cfg.target_right);
    run_lane(1, t.capture_left, t.backward_left, t.wraps_left, t.run_enable,
             cfg.target_left);
    r.duty_right = duty_held[0];
    r.duty_left  = duty_held[1];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_req_t want;
    if (!rst_ni) begin
      cfg.prop_gain    = PROP_GAIN_RST;
      cfg.integ_gain   = INTEG_GAIN_RST;
      cfg.target_right = TARGET_RST;
      cfg.target_left  = TARGET_RST;
      cfg.duty_limit   = DUTY_LIMIT_RST;
      for (int m = 0; m < 2; m++) begin
        last_cap[m]  = '0;
        last_err[m]  = 0;
        duty_held[m] = '0;
      end
      duty_q.delete();
      fail_cnt_o = 0;
      pending_o  = 0;
    end else begin
      // response side first: a request taken this edge cannot answer this edge
      if (out_valid_i && !out_stall_i) begin
        if (duty_q.size() == 0) begin
          $display("%0t: unexpected duty response: got right %0d left %0d",
                   $time, out_req_i.duty_right, out_req_i.duty_left);
          fail_cnt_o++;
        end else begin
          want = duty_q.pop_front();
          if (out_req_i.duty_right !== want.duty_right ||
              out_req_i.duty_left !== want.duty_left) begin
            $display("%0t: duty mismatch: expected right %0d left %0d, got right %0d left %0d",
                     $time, want.duty_right, want.duty_left,
                     out_req_i.duty_right, out_req_i.duty_left);
            fail_cnt_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) duty_q.push_back(predict_duties(in_req_i));
      // register writes; unused indexes fall through
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_PROP_GAIN:    cfg.prop_gain    = cfg_wdata_i;
          REG_INTEG_GAIN:   cfg.integ_gain   = cfg_wdata_i;
          REG_TARGET_RIGHT: cfg.target_right = cfg_wdata_i;
          REG_TARGET_LEFT:  cfg.target_left  = cfg_wdata_i;
          REG_DUTY_LIMIT:   cfg.duty_limit   = cfg_wdata_i;
          default: ;
        endcase
      end
      pending_o = duty_q.size();
    end
  end

endmodule

/* verif/dual_incremental_pi_speed_control_tb.sv */
// Top of the dual incremental PI speed control testbench: clock, reset, tick requests,
// register programming and the verdict. Depends on dipsc_pkg, dipsc_checker and the block.
module dual_incremental_pi_speed_control_tb;
  import dipsc_pkg::*;

  localparam logic [IDX_W-1:0] REG_UNUSED_FIRST = 3'd5;
  localparam int SEG_ITEMS = 122;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              cfg_we_i    = 1'b0;
  logic [IDX_W-1:0]  cfg_idx_i   = REG_PROP_GAIN;
  logic [DATA_W-1:0] cfg_wdata_i = '0;
  logic              in_valid_i  = 1'b0;
  in_req_t           in_req_i    = '0;
  logic              out_stall_i = 1'b0;
  logic              in_stall_o;
  logic              out_valid_o;
  out_req_t          out_req_o;

  int fail_cnt;
  int pending;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // Encoder positions for well-formed random tick sequences
  logic [DATA_W-1:0] enc_r = '0;
  logic [DATA_W-1:0] enc_l = '0;
  logic              dir_r = 1'b0;
  logic              dir_l = 1'b0;

  dual_incremental_pi_speed_control u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o)
  );

  dipsc_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_i   (out_req_o),
    .fail_cnt_o  (fail_cnt),
    .pending_o   (pending)
  );

  always #4 clk_i = ~clk_i;

  // Response side back-pressure
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // Watchdog
  initial begin
    #(2_000_000);
    $display("Mismatches found");
    $finish;
  end

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
  endtask

  // All five registers, then a write to an unused index that must change nothing
  task automatic program_regs(input logic [DATA_W-1:0] kp, input logic [DATA_W-1:0] ki,
                              input logic [DATA_W-1:0] tr, input logic [DATA_W-1:0] tl,
                              input logic [DATA_W-1:0] lim);
    write_reg(REG_PROP_GAIN, kp);
    write_reg(REG_INTEG_GAIN, ki);
    write_reg(REG_TARGET_RIGHT, tr);
    write_reg(REG_TARGET_LEFT, tl);
    write_reg(REG_DUTY_LIMIT, lim);
    write_reg(REG_UNUSED_FIRST + IDX_W'($urandom_range(2)), DATA_W'($urandom));
    cfg_we_i <= 1'b0;
  endtask

  // Hold off new requests until every owed response is back
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Offer one tick request, with random idle cycles ahead of it
  task automatic push_tick(input in_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  function automatic in_req_t mk_tick(input logic [DATA_W-1:0] cr, input logic br,
                                      input logic [WRAP_W-1:0] wr, input logic [DATA_W-1:0] cl,
                                      input logic bl, input logic [WRAP_W-1:0] wl,
                                      input logic run);
    in_req_t t;
    t.capture_right  = cr;
    t.backward_right = br;
    t.wraps_right    = wr;
    t.capture_left   = cl;
    t.backward_left  = bl;
    t.wraps_left     = wl;
    t.run_enable     = run;
    return t;
  endfunction

  // Mostly plausible encoder motion, a quarter fully random noise
  function automatic in_req_t next_tick();
    in_req_t t;
    logic [DATA_W-1:0] step_r, step_l;
    logic [63:0]       noise;
    if ($urandom_range(3) == 0) begin
      noise = {$urandom, $urandom};
      t = noise[$bits(in_req_t)-1:0];
      enc_r = t.capture_right;
      enc_l = t.capture_left;
    end else begin
      if ($urandom_range(19) == 0) dir_r = ~dir_r;
      if ($urandom_range(19) == 0) dir_l = ~dir_l;
      step_r = DATA_W'($urandom_range(1500));
      step_l = DATA_W'($urandom_range(1500));
      enc_r = dir_r ? enc_r - step_r : enc_r + step_r;
      enc_l = dir_l ? enc_l - step_l : enc_l + step_l;
      t.capture_right  = enc_r;
      t.backward_right = dir_r;
      t.wraps_right    = ($urandom_range(9) == 0) ? WRAP_W'($urandom) : '0;
      t.capture_left   = enc_l;
      t.backward_left  = dir_l;
      t.wraps_left     = ($urandom_range(9) == 0) ? WRAP_W'($urandom) : '0;
      t.run_enable     = ($urandom_range(19) != 0);
    end
    return t;
  endfunction

  // Register value: an extreme, anything, or a plausible working value
  function automatic logic [DATA_W-1:0] pick_value(input int typ_max);
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return DATA_W'($urandom);
      default: return DATA_W'($urandom_range(typ_max));
    endcase
  endfunction

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 34;
    recv_idle_pct = 76;

    // Reset settings: zero target, extreme captures, wraps and directions
    push_tick(mk_tick(16'h0000, 1'b0, 4'h0, 16'h0000, 1'b0, 4'h0, 1'b1));
    push_tick(mk_tick(16'hffff, 1'b0, 4'hf, 16'hffff, 1'b1, 4'hf, 1'b1));
    push_tick(mk_tick(16'h0000, 1'b1, 4'h0, 16'h0000, 1'b0, 4'h0, 1'b1));
    // run off: captures stored, duties held
    push_tick(mk_tick(16'h1234, 1'b0, 4'h0, 16'h8000, 1'b1, 4'h0, 1'b0));
    push_tick(mk_tick(16'h1234, 1'b0, 4'h0, 16'h8000, 1'b0, 4'h0, 1'b1));

    // Maximum gains, targets and limit: drive up to the clamp
    settle();
    program_regs('1, '1, '1, '1, '1);
    push_tick(mk_tick(16'hffff, 1'b1, 4'h0, 16'hffff, 1'b0, 4'h0, 1'b1));
    push_tick(mk_tick(16'hffff, 1'b0, 4'h0, 16'hffff, 1'b0, 4'h0, 1'b1));
    push_tick(mk_tick(16'h5555, 1'b1, 4'h3, 16'haaaa, 1'b0, 4'hc, 1'b0));

    // Lowered limit: held duty stays above it until the next PI update
    settle();
    program_regs('0, '0, '0, '0, 16'd100);
    push_tick(mk_tick(16'h5555, 1'b0, 4'h0, 16'haaaa, 1'b0, 4'h0, 1'b0));
    push_tick(mk_tick(16'h5555, 1'b0, 4'h0, 16'haaaa, 1'b0, 4'h0, 1'b1));

    // Fractional gains: truncation of negative increments toward zero
    settle();
    program_regs(16'h0180, 16'h0003, 16'd5, 16'd7, '1);
    push_tick(mk_tick(16'h5557, 1'b0, 4'h0, 16'haaad, 1'b0, 4'h0, 1'b1));
    push_tick(mk_tick(16'h5500, 1'b1, 4'h0, 16'haa00, 1'b1, 4'h0, 1'b1));
    push_tick(mk_tick(16'h5510, 1'b0, 4'h0, 16'haa09, 1'b0, 4'h0, 1'b1));

    // Zero limit
    settle();
    program_regs('0, '0, '0, '0, '0);
    push_tick(mk_tick(16'h0000, 1'b1, 4'h0, 16'h0000, 1'b1, 4'h0, 1'b1));

    // Back to default gains with a working target
    settle();
    program_regs(PROP_GAIN_RST, INTEG_GAIN_RST, 16'd800, 16'd800, DUTY_LIMIT_RST);
    push_tick(mk_tick(16'h0320, 1'b0, 4'h0, 16'h0300, 1'b0, 4'h0, 1'b1));
    push_tick(mk_tick(16'h0600, 1'b0, 4'h1, 16'h0640, 1'b0, 4'h0, 1'b1));

    // Random phases, each split into segments with fresh settings
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 34;
          recv_idle_pct = 76;
        end
        1: begin
          send_idle_pct = 76;
          recv_idle_pct = 34;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int seg = 0; seg < 3; seg++) begin
        settle();
        program_regs(pick_value(4096), pick_value(2048), pick_value(1500),
                     pick_value(1500), pick_value(16800));
        for (int n = 0; n < SEG_ITEMS; n++) push_tick(next_tick());
      end
    end

    settle();
    repeat (8) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
